@@ rtl/drpf_pkg.sv @@
// Shared widths, configuration codes and handshake types for the decimal range prime filter.
package drpf_pkg;

	localparam int NUM_W      = 30;
	localparam int DIGIT_W    = 4;
	localparam int CNT_W      = 4;
	localparam int DIV_W      = 16;
	localparam int SQ_W       = 32;
	localparam int CFG_IDX_W  = 1;

	localparam int MAX_DIGITS_DEF = 9;

	localparam logic [NUM_W-1:0]   LOW_BOUND_RST  = NUM_W'(0);
	localparam logic [NUM_W-1:0]   HIGH_BOUND_RST = NUM_W'(999999999);
	localparam logic [DIGIT_W-1:0] DIGIT_MAX      = DIGIT_W'(9);

	localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = CFG_IDX_W'(1);

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] remainder;
	} rem_rsp_t;

endpackage

@@ rtl/drpf_rem_unit.sv @@
// Restoring remainder unit that retires one dividend bit per cycle.
module drpf_rem_unit
	import drpf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);

	localparam int STEP_W = $clog2(NUM_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  shift_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    trial_sub;

	always_comb begin
		trial     = {rem_q, shift_q[NUM_W-1]};
		trial_sub = trial - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			shift_q   <= req.dividend;
			divisor_q <= req.divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor_q}) begin
				rem_q <= trial_sub[DIV_W-1:0];
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

@@ rtl/decimal_range_prime_filter.sv @@
// Top level: decimal digit accumulator, range check and trial division sequencer.
//
//   channel   direction  handshake                  payload
//   digit     in         digit_valid / digit_stall  digit, last_digit
//   result    out        result_valid / result_stall number_value, passed, overflowed
//   cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A digit that does not end the number is accumulated without stalling the digit channel.
// A last digit stalls the digit channel while the number is range-checked and tested by
// trial division, one divisor at a time through the one-bit-per-cycle remainder unit, and
// until its verdict enters the output register.
// Reset clears the accumulator and loads the bound registers; there is no clearing pass.
// A stalled result waits in its output register while new digits keep being taken.
module decimal_range_prime_filter
	import drpf_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 digit_valid,
	output logic                 digit_stall,
	input  logic [DIGIT_W-1:0]   digit,
	input  logic                 last_digit,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [NUM_W-1:0]     number_value,
	output logic                 passed,
	output logic                 overflowed,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUM_W-1:0]     cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_TEST  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [NUM_W-1:0]   low_q;
	logic [NUM_W-1:0]   high_q;
	logic [NUM_W-1:0]   acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic               over_q;
	logic               pass_q;
	logic [DIV_W-1:0]   div_q;
	logic [SQ_W-1:0]    sq_q;
	logic               res_valid_q;
	logic [NUM_W-1:0]   res_num_q;
	logic               res_pass_q;
	logic               res_over_q;

	logic               digit_acc;
	logic [DIGIT_W-1:0] dig_clamped;
	logic [NUM_W-1:0]   acc_next;
	logic [CNT_W-1:0]   cnt_next;
	logic               out_free;
	logic               in_range;
	rem_req_t           rem_req;
	rem_rsp_t           rem_rsp;

	assign digit_stall  = (state_q != S_IDLE);
	assign digit_acc    = digit_valid && !digit_stall;
	assign cfg_ready    = 1'b1;
	assign out_free     = !res_valid_q || !result_stall;
	assign in_range     = (num_q >= low_q) && (num_q <= high_q) && (num_q >= NUM_W'(2));

	always_comb begin
		dig_clamped = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
		if (cnt_q < CNT_W'(MAX_DIGITS)) begin
			acc_next = NUM_W'({acc_q, 3'b000}) + NUM_W'({acc_q, 1'b0})
				+ NUM_W'(dig_clamped);
			cnt_next = cnt_q + CNT_W'(1);
		end else begin
			acc_next = acc_q;
			cnt_next = CNT_W'(MAX_DIGITS + 1);
		end
	end

	assign rem_req.start    = (state_q == S_TEST) && (sq_q <= SQ_W'(num_q));
	assign rem_req.dividend = num_q;
	assign rem_req.divisor  = div_q;

	drpf_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_BOUND_RST;
			high_q <= HIGH_BOUND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOW_BOUND:  low_q  <= cfg_data;
				CFG_HIGH_BOUND: high_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !result_stall && (state_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (digit_acc) begin
						if (last_digit) begin
							acc_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_CHECK;
						end else begin
							acc_q <= acc_next;
							cnt_q <= cnt_next;
						end
					end
				end
				S_CHECK: begin
					state_q <= (!over_q && in_range) ? S_TEST : S_DONE;
				end
				S_TEST: begin
					state_q <= (sq_q > SQ_W'(num_q)) ? S_DONE : S_DIV;
				end
				S_DIV: begin
					if (rem_rsp.done) begin
						state_q <= (rem_rsp.remainder == '0) ? S_DONE : S_TEST;
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (digit_acc && last_digit) begin
					num_q  <= acc_next;
					over_q <= (cnt_next > CNT_W'(MAX_DIGITS));
				end
			end
			S_CHECK: begin
				pass_q <= 1'b0;
				div_q  <= DIV_W'(2);
				sq_q   <= SQ_W'(4);
			end
			S_TEST: begin
				if (sq_q > SQ_W'(num_q)) begin
					pass_q <= 1'b1;
				end
			end
			S_DIV: begin
				if (rem_rsp.done && (rem_rsp.remainder != '0)) begin
					div_q <= div_q + DIV_W'(1);
					sq_q  <= sq_q + SQ_W'({div_q, 1'b1});
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_num_q  <= num_q;
					res_pass_q <= pass_q;
					res_over_q <= over_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign number_value = res_num_q;
	assign passed       = res_pass_q;
	assign overflowed   = res_over_q;

endmodule

@@ rtl/drpf_checker.sv @@
// Port-level checker for the decimal range prime filter and its bind statement.
module drpf_checker
	import drpf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               digit_valid,
	input logic               digit_stall,
	input logic               last_digit,
	input logic               result_valid,
	input logic               result_stall,
	input logic [NUM_W-1:0]   number_value,
	input logic               passed,
	input logic               overflowed
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(number_value)
			&& $stable(passed) && $stable(overflowed))
		else $error("Stalled result changed before its transfer.");

	a_pass_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(passed && overflowed))
		else $error("Result passed with overflow set.");

	a_pass_prime_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && passed |-> (number_value == NUM_W'(2))
			|| (number_value[0] && (number_value != NUM_W'(1))))
		else $error("Passed number is below two or even.");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !digit_stall && last_digit |=> digit_stall)
		else $error("Digit channel open right after a last digit transfer.");

endmodule

bind decimal_range_prime_filter drpf_checker u_drpf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.digit_valid  (digit_valid),
	.digit_stall  (digit_stall),
	.last_digit   (last_digit),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.number_value (number_value),
	.passed       (passed),
	.overflowed   (overflowed)
);

@@ tb/sv/drpf_verdict_checker.sv @@
// Checker for the decimal range prime filter: predicts each verdict and compares the outputs.
`timescale 1ns / 1ps

module drpf_verdict_checker
	import drpf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 digit_valid,
	input  logic                 digit_stall,
	input  logic [DIGIT_W-1:0]   digit,
	input  logic                 last_digit,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  logic [NUM_W-1:0]     number_value,
	input  logic                 passed,
	input  logic                 overflowed,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUM_W-1:0]     cfg_data,
	output int                   mismatch_count,
	output int                   verdicts_pending
);

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic             passed;
		logic             overflowed;
	} verdict_t;

	verdict_t         verdict_q[$];
	logic [NUM_W-1:0] low_bound_q  = LOW_BOUND_RST;
	logic [NUM_W-1:0] high_bound_q = HIGH_BOUND_RST;
	logic [NUM_W-1:0] number_acc   = '0;
	logic [CNT_W-1:0] digits_taken = '0;

	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		logic [DIGIT_W-1:0] dv;
		longint unsigned    divisor;
		logic               prime;
		verdict_t           want;
		if (!arst_n) begin
			low_bound_q  = LOW_BOUND_RST;
			high_bound_q = HIGH_BOUND_RST;
			number_acc   = '0;
			digits_taken = '0;
			verdict_q.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					$error("result transfer with number_value %0d while no result was due",
						number_value);
					mismatch_count++;
				end else begin
					want = verdict_q.pop_front();
					if (number_value !== want.number) begin
						$error("number_value: expected %0d, actual %0d", want.number,
							number_value);
						mismatch_count++;
					end
					if (passed !== want.passed) begin
						$error("passed: expected %0b, actual %0b (number %0d)", want.passed,
							passed, want.number);
						mismatch_count++;
					end
					if (overflowed !== want.overflowed) begin
						$error("overflowed: expected %0b, actual %0b (number %0d)",
							want.overflowed, overflowed, want.number);
						mismatch_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LOW_BOUND:  low_bound_q  = cfg_data;
					CFG_HIGH_BOUND: high_bound_q = cfg_data;
					default: ;
				endcase
			end
			if (digit_valid && !digit_stall) begin
				dv = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
				if (digits_taken < CNT_W'(MAX_DIGITS_DEF)) begin
					number_acc   = NUM_W'(number_acc * 10 + dv);
					digits_taken = digits_taken + 1'b1;
				end else begin
					digits_taken = CNT_W'(MAX_DIGITS_DEF + 1);
				end
				if (last_digit) begin
					prime = (number_acc >= 2);
					for (divisor = 2; prime && divisor * divisor <= number_acc; divisor++)
						if (number_acc % divisor == 0)
							prime = 1'b0;
					want.number     = number_acc;
					want.overflowed = (digits_taken > CNT_W'(MAX_DIGITS_DEF));
					want.passed     = !want.overflowed && number_acc >= low_bound_q &&
						number_acc <= high_bound_q && prime;
					verdict_q.push_back(want);
					number_acc   = '0;
					digits_taken = '0;
				end
			end
		end
		verdicts_pending = verdict_q.size();
	end

endmodule

@@ tb/sv/decimal_range_prime_filter_tb.sv @@
// Top of the decimal range prime filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module decimal_range_prime_filter_tb;
	import drpf_pkg::*;

	localparam int CYCLE_LIMIT = 10_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 digit_valid;
	logic                 digit_stall;
	logic [DIGIT_W-1:0]   digit;
	logic                 last_digit;
	logic                 result_valid;
	logic                 result_stall;
	logic [NUM_W-1:0]     number_value;
	logic                 passed;
	logic                 overflowed;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NUM_W-1:0]     cfg_data;
	int                   mismatch_count;
	int                   verdicts_pending;
	int unsigned          cycle_count = 0;

	logic [DIGIT_W-1:0] digit_seq[$];
	bit                 digit_gaps_on;

	decimal_range_prime_filter dut (.*);

	drpf_verdict_checker checker_inst (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int unsigned gap_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int unsigned stall_len;
		forever begin
			result_stall <= 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6))
				@(negedge clk);
			stall_len = gap_cycles();
			if (stall_len != 0) begin
				result_stall <= 1'b1;
				repeat (stall_len) @(negedge clk);
			end
		end
	end

	// Sends the queued digits as one number; entered and left at a falling edge.
	task automatic send_sequence();
		int          i;
		int unsigned gap;
		for (i = 0; i < digit_seq.size(); i++) begin
			gap = digit_gaps_on ? gap_cycles() : 0;
			if (gap != 0) begin
				digit_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			digit_valid <= 1'b1;
			digit       <= digit_seq[i];
			last_digit  <= (i == digit_seq.size() - 1);
			@(posedge clk);
			while (digit_stall) @(posedge clk);
			@(negedge clk);
		end
		digit_seq.delete();
	endtask

	task automatic push_decimal(input int unsigned value, input int width);
		int unsigned scale;
		scale = 1;
		repeat (width - 1) scale *= 10;
		repeat (width) begin
			digit_seq.push_back(DIGIT_W'((value / scale) % 10));
			scale /= 10;
		end
	endtask

	task automatic send_random_numbers(input int digit_budget);
		int                 sent;
		int unsigned        len;
		int unsigned        r;
		int unsigned        i;
		int unsigned        even_pos;
		logic [DIGIT_W-1:0] d;
		sent = 0;
		while (sent < digit_budget) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(1, 4);
			else if (r < 85)
				len = $urandom_range(5, 6);
			else if (r < 93)
				len = $urandom_range(7, 9);
			else
				len = $urandom_range(10, 12);
			// Long numbers get an even final kept digit so the divisor search ends early.
			even_pos = (len <= MAX_DIGITS_DEF) ? len - 1 : MAX_DIGITS_DEF - 1;
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 6) == 0)
					d = DIGIT_W'($urandom_range(10, 15));
				else
					d = DIGIT_W'($urandom_range(0, 9));
				if (len >= 7 && i == even_pos)
					d = DIGIT_W'(2 * $urandom_range(0, 4));
				digit_seq.push_back(d);
			end
			sent += len;
			digit_gaps_on = ($urandom_range(0, 3) != 0);
			send_sequence();
		end
	endtask

	task automatic wait_idle();
		digit_valid <= 1'b0;
		while (verdicts_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_bounds(input logic [NUM_W-1:0] low, input logic [NUM_W-1:0] high);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_LOW_BOUND;
		cfg_data  <= low;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_index <= CFG_HIGH_BOUND;
		cfg_data  <= high;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [NUM_W-1:0] low;
		arst_n        = 1'b0;
		digit_valid   = 1'b0;
		digit         = '0;
		last_digit    = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_LOW_BOUND;
		cfg_data      = '0;
		digit_gaps_on = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero, one, the smallest prime, a code above nine, and a code above nine inside 19.
		push_decimal(0, 1);
		send_sequence();
		push_decimal(1, 1);
		send_sequence();
		push_decimal(2, 1);
		send_sequence();
		digit_seq.push_back(DIGIT_W'(15));
		send_sequence();
		digit_seq.push_back(DIGIT_W'(1));
		digit_seq.push_back(DIGIT_W'(10));
		send_sequence();
		// A nine-digit prime, then ten digits that overflow.
		push_decimal(100000007, 9);
		send_sequence();
		push_decimal(999999998, 9);
		digit_seq.push_back(DIGIT_W'(3));
		send_sequence();
		send_random_numbers(10);

		wait_idle();
		set_bounds('0, '1);
		send_random_numbers(10);

		wait_idle();
		low = NUM_W'($urandom_range(0, 300));
		set_bounds(low, low + NUM_W'($urandom_range(0, 700)));
		send_random_numbers(10);

		wait_idle();
		set_bounds(NUM_W'($urandom()), NUM_W'($urandom()));
		send_random_numbers(10);

		wait_idle();
		set_bounds('1, '1);
		send_random_numbers(10);

		wait_idle();
		set_bounds(NUM_W'(600), NUM_W'(50));
		send_random_numbers(10);

		wait_idle();
		set_bounds(LOW_BOUND_RST, HIGH_BOUND_RST);
		send_random_numbers(10);

		digit_valid <= 1'b0;
		while (verdicts_pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
